// ===== hdl/rsnh_pkg.sv =====
`timescale 1ns / 1ps
package rsnh_pkg;

    // input opcodes carried in the slave tuser
    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_LOAD   = 2'd1;
    localparam logic [1:0] FN_CAST   = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    // fixed datapath widths
    localparam int T_W   = 31;   // quantized distance bits
    localparam int REM_W = 83;   // |tn| << 16
    localparam int DEN_W = 51;   // |den|

    // cycles from the last scan beat until the best hit has settled
    localparam logic [5:0] DRAIN_LAST = 6'd36;

    localparam logic [4:0] TAG_NONE = 5'h1F;

    // one stored segment
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic [3:0]         tag_p;
        logic [3:0]         tag_e;
    } t_seg;

    // one candidate moving down the divider chain
    typedef struct packed {
        logic               ok;
        logic               sat;
        logic [REM_W-1:0]   rem;
        logic [DEN_W-1:0]   den;
        logic [T_W-1:0]     q;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic [3:0]         tag_p;
        logic [3:0]         tag_e;
    } t_div_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UDIR,
        ST_SCAN,
        ST_DRAIN,
        ST_NDIR,
        ST_MUL,
        ST_SUM,
        ST_MUL2,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        UV_IDLE,
        UV_SCALE,
        UV_SQ,
        UV_SUM,
        UV_SQRT,
        UV_RND,
        UV_DIV,
        UV_DONE
    } t_uv_state;

endpackage

// ===== hdl/ray_segment_nearest_hit_reflect.sv =====
`timescale 1ns / 1ps
// Clear and load beats are taken while idle; func 3 is dropped.
// A cast holds the input through the scan, the drain and one direction normalization
// (up to 31 scaling steps, 32-step square root, 18-step divide; none for a zero
// direction), plus, on a hit, the hit edge normalization and the MUL, SUM, MUL2 states.
// The result is valid from the cycle the input reopens; a waiting result stalls the finish.
// Synchronous active-low reset clears the segment count and all control state.
module ray_segment_nearest_hit_reflect
    import rsnh_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_POLYGONS = 16,
    parameter int MAX_EDGES    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // point_a_x, point_a_y, point_b_x, point_b_y, tag_poly, tag_edge, zero pad
    input  logic [143:0] i_s_axis_tdata,
    // func
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // hit_t, hit_x, hit_y, refl_x, refl_y, hit_poly, hit_edge, zero pad
    output logic [143:0] o_m_axis_tdata,
    // valid_hit
    output logic         o_m_axis_tuser
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    // round-half-away shift by 16
    function automatic logic signed [34:0] f_rnd16(input logic signed [49:0] x);
        logic [49:0] m;
        logic [49:0] r;
        m = x[49] ? 50'(-x) : 50'(x);
        r = (m + 50'd32768) >> 16;
        f_rnd16 = x[49] ? -$signed(35'(r)) : $signed(35'(r));
    endfunction

    // round-half-away shift by 31
    function automatic logic signed [24:0] f_rnd31(input logic signed [54:0] x);
        logic [54:0] m;
        logic [54:0] r;
        m = x[54] ? 55'(-x) : 55'(x);
        r = (m + (55'd1 << 30)) >> 31;
        f_rnd31 = x[54] ? -$signed(25'(r)) : $signed(25'(r));
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [35:0] x);
        if (x > 36'sd2147483647) begin
            f_sat32 = 32'sh7FFFFFFF;
        end else if (x < -36'sd2147483648) begin
            f_sat32 = 32'sh80000000;
        end else begin
            f_sat32 = x[31:0];
        end
    endfunction

    function automatic logic signed [17:0] f_clamp(input logic signed [25:0] x);
        if (x > 26'sd65536) begin
            f_clamp = 18'sd65536;
        end else if (x < -26'sd65536) begin
            f_clamp = -18'sd65536;
        end else begin
            f_clamp = x[17:0];
        end
    endfunction

    // input beat fields
    logic [1:0]         w_func;
    logic signed [31:0] w_ax;
    logic signed [31:0] w_ay;
    logic signed [31:0] w_bx;
    logic signed [31:0] w_by;
    logic signed [4:0]  w_tp;
    logic signed [4:0]  w_te;
    logic               w_in_acc;
    logic               w_load_ok;
    t_seg               w_new_seg;

    assign w_func = i_s_axis_tuser;
    assign w_ax   = i_s_axis_tdata[31:0];
    assign w_ay   = i_s_axis_tdata[63:32];
    assign w_bx   = i_s_axis_tdata[95:64];
    assign w_by   = i_s_axis_tdata[127:96];
    assign w_tp   = i_s_axis_tdata[132:128];
    assign w_te   = i_s_axis_tdata[137:133];

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_scan;
    logic [5:0]         r_drain;
    logic               r_found;
    logic               c_ready;
    logic               c_uv_start;
    logic               c_shift;
    logic               c_out_load;

    // cast context
    logic signed [31:0] r_ax;
    logic signed [31:0] r_ay;
    logic [4:0]         r_tp;
    logic [4:0]         r_te;
    logic signed [17:0] r_ux;
    logic signed [17:0] r_uy;
    logic signed [17:0] r_nx;
    logic signed [17:0] r_ny;

    // best hit so far
    logic [T_W-1:0]     r_best_t;
    logic signed [32:0] r_best_vx;
    logic signed [32:0] r_best_vy;
    logic [3:0]         r_best_tp;
    logic [3:0]         r_best_te;

    // unit vector unit
    logic               w_uv_done;
    logic signed [32:0] w_uv_a;
    logic signed [32:0] w_uv_b;
    logic signed [17:0] w_uv_ua;
    logic signed [17:0] w_uv_ub;

    assign w_in_acc  = i_s_axis_tvalid & o_s_axis_tready;
    assign w_load_ok = (w_func == FN_LOAD) && (r_count < CNT_W'(MAX_SEGMENTS))
                       && !w_tp[4] && (32'(w_tp[3:0]) < MAX_POLYGONS)
                       && !w_te[4] && (32'(w_te[3:0]) < MAX_EDGES);

    assign w_new_seg.sx    = w_ax;
    assign w_new_seg.sy    = w_ay;
    assign w_new_seg.ex    = w_bx;
    assign w_new_seg.ey    = w_by;
    assign w_new_seg.tag_p = w_tp[3:0];
    assign w_new_seg.tag_e = w_te[3:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc && w_func == FN_CAST) n_state = ST_UDIR;
            ST_UDIR:  if (w_uv_done) n_state = ST_SCAN;
            ST_SCAN:  if (r_scan == CNT_W'(MAX_SEGMENTS - 1)) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (r_drain == DRAIN_LAST) begin
                    n_state = r_found ? ST_NDIR : ST_FIN;
                end
            end
            ST_NDIR:  if (w_uv_done) n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_FIN;
            ST_FIN:   if (!o_m_axis_tvalid || i_m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        c_ready    = (r_state == ST_IDLE);
        c_shift    = (r_state == ST_SCAN);
        c_uv_start = ((r_state == ST_IDLE) && w_in_acc && (w_func == FN_CAST))
                     || ((r_state == ST_DRAIN) && (r_drain == DRAIN_LAST) && r_found);
        c_out_load = (r_state == ST_FIN) && (!o_m_axis_tvalid || i_m_axis_tready);
    end

    assign o_s_axis_tready = c_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_scan  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && w_func == FN_CLEAR) begin
                r_count <= '0;
            end else if (w_in_acc && w_load_ok) begin
                r_count <= r_count + CNT_W'(1);
            end
            r_scan  <= c_shift ? r_scan + CNT_W'(1) : '0;
            r_drain <= (r_state == ST_DRAIN) ? r_drain + 6'd1 : 6'd0;
        end
    end

    // segment store: a ring of cells, rotated once per cast
    t_seg w_seg [MAX_SEGMENTS];

    for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_seg
        rsnh_seg_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (c_shift),
            .i_load     (w_in_acc && w_load_ok && (r_count == CNT_W'(k))),
            .i_load_seg (w_new_seg),
            .i_next     (w_seg[(k + 1) % MAX_SEGMENTS]),
            .o_seg      (w_seg[k])
        );
    end

    // stage 1: differences and skip test
    logic               r_s1_ok;
    logic               r_s1_skip;
    logic signed [32:0] r_s1_vx;
    logic signed [32:0] r_s1_vy;
    logic signed [32:0] r_s1_dx;
    logic signed [32:0] r_s1_dy;
    logic [3:0]         r_s1_tp;
    logic [3:0]         r_s1_te;

    // stage 2: products
    logic               r_s2_ok;
    logic signed [50:0] r_p_uvy;
    logic signed [50:0] r_p_uvx;
    logic signed [50:0] r_p_udy;
    logic signed [50:0] r_p_udx;
    logic signed [65:0] r_p_vdy;
    logic signed [65:0] r_p_wdx;
    logic signed [32:0] r_s2_vx;
    logic signed [32:0] r_s2_vy;
    logic [3:0]         r_s2_tp;
    logic [3:0]         r_s2_te;

    // stage 3: den, sn, tn
    logic               r_s3_ok;
    logic signed [51:0] r_den;
    logic signed [51:0] r_sn;
    logic signed [66:0] r_tn;
    logic signed [32:0] r_s3_vx;
    logic signed [32:0] r_s3_vy;
    logic [3:0]         r_s3_tp;
    logic [3:0]         r_s3_te;

    // stage 4: hit tests and magnitudes
    logic               r_s4_ok;
    logic [66:0]        r_s4_tmag;
    logic [DEN_W-1:0]   r_s4_dmag;
    logic signed [32:0] r_s4_vx;
    logic signed [32:0] r_s4_vy;
    logic [3:0]         r_s4_tp;
    logic [3:0]         r_s4_te;
    logic               w_in_range;

    // stage 5: divider entry
    t_div_beat          r_s5;
    t_div_beat          w_beat [T_W + 1];

    always_comb begin
        if (!r_den[51]) begin
            w_in_range = !r_sn[51] && (r_sn <= r_den);
        end else begin
            w_in_range = (r_sn <= 52'sd0) && (r_sn >= r_den);
        end
    end

    // valid bits of the front stages, and the divider entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ok <= 1'b0;
            r_s2_ok <= 1'b0;
            r_s3_ok <= 1'b0;
            r_s4_ok <= 1'b0;
            r_s5.ok <= 1'b0;
        end else begin
            r_s1_ok <= c_shift && (r_scan < r_count);
            r_s2_ok <= r_s1_ok && !r_s1_skip;
            r_s3_ok <= r_s2_ok;
            r_s4_ok <= r_s3_ok && (r_den != 52'sd0) && w_in_range
                       && (r_tn != 67'sd0) && (r_tn[66] == r_den[51]);
            r_s5.ok <= r_s4_ok;
        end

        r_s5.sat   <= r_s4_tmag >= 67'({r_s4_dmag, 15'd0});
        r_s5.rem   <= {r_s4_tmag, 16'd0};
        r_s5.den   <= r_s4_dmag;
        r_s5.q     <= (r_s4_tmag >= 67'({r_s4_dmag, 15'd0})) ? '1 : '0;
        r_s5.vx    <= r_s4_vx;
        r_s5.vy    <= r_s4_vy;
        r_s5.tag_p <= r_s4_tp;
        r_s5.tag_e <= r_s4_te;
    end

    // front stage payload
    always_ff @(posedge i_clk) begin
        r_s1_vx   <= 33'(w_seg[0].ex) - 33'(w_seg[0].sx);
        r_s1_vy   <= 33'(w_seg[0].ey) - 33'(w_seg[0].sy);
        r_s1_dx   <= 33'(r_ax) - 33'(w_seg[0].sx);
        r_s1_dy   <= 33'(r_ay) - 33'(w_seg[0].sy);
        r_s1_skip <= ({1'b0, w_seg[0].tag_p} == r_tp) && ({1'b0, w_seg[0].tag_e} == r_te);
        r_s1_tp   <= w_seg[0].tag_p;
        r_s1_te   <= w_seg[0].tag_e;

        r_p_uvy <= 51'(r_ux) * 51'(r_s1_vy);
        r_p_uvx <= 51'(r_uy) * 51'(r_s1_vx);
        r_p_udy <= 51'(r_ux) * 51'(r_s1_dy);
        r_p_udx <= 51'(r_uy) * 51'(r_s1_dx);
        r_p_vdy <= 66'(r_s1_vx) * 66'(r_s1_dy);
        r_p_wdx <= 66'(r_s1_vy) * 66'(r_s1_dx);
        r_s2_vx <= r_s1_vx;
        r_s2_vy <= r_s1_vy;
        r_s2_tp <= r_s1_tp;
        r_s2_te <= r_s1_te;

        r_den   <= 52'(r_p_uvy) - 52'(r_p_uvx);
        r_sn    <= 52'(r_p_udy) - 52'(r_p_udx);
        r_tn    <= 67'(r_p_vdy) - 67'(r_p_wdx);
        r_s3_vx <= r_s2_vx;
        r_s3_vy <= r_s2_vy;
        r_s3_tp <= r_s2_tp;
        r_s3_te <= r_s2_te;

        r_s4_tmag <= r_tn[66] ? 67'(-r_tn) : 67'(r_tn);
        r_s4_dmag <= r_den[51] ? DEN_W'(-r_den) : DEN_W'(r_den);
        r_s4_vx   <= r_s3_vx;
        r_s4_vy   <= r_s3_vy;
        r_s4_tp   <= r_s3_tp;
        r_s4_te   <= r_s3_te;
    end

    // divider chain, one quotient bit per cell
    assign w_beat[0] = r_s5;

    for (genvar g = 0; g < T_W; g++) begin : g_div
        rsnh_div_cell #(
            .BIT (T_W - 1 - g)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat[g]),
            .o_beat  (w_beat[g + 1])
        );
    end

    // nearest hit; strict compare keeps the earliest on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (c_ready && w_in_acc && w_func == FN_CAST) begin
            r_found <= 1'b0;
        end else if (w_beat[T_W].ok && (!r_found || w_beat[T_W].q < r_best_t)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_beat[T_W].ok && (!r_found || w_beat[T_W].q < r_best_t)) begin
            r_best_t  <= w_beat[T_W].q;
            r_best_vx <= w_beat[T_W].vx;
            r_best_vy <= w_beat[T_W].vy;
            r_best_tp <= w_beat[T_W].tag_p;
            r_best_te <= w_beat[T_W].tag_e;
        end
    end

    // direction of the ray, then normal of the hit edge
    assign w_uv_a = (r_state == ST_IDLE) ? 33'(w_bx) : r_best_vy;
    assign w_uv_b = (r_state == ST_IDLE) ? 33'(w_by) : 33'(-r_best_vx);

    rsnh_uvec u_uvec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_uv_start),
        .i_a     (w_uv_a),
        .i_b     (w_uv_b),
        .o_done  (w_uv_done),
        .o_ua    (w_uv_ua),
        .o_ub    (w_uv_ub)
    );

    // hit point and reflection
    logic signed [49:0] r_ptx;
    logic signed [49:0] r_pty;
    logic signed [35:0] r_pdx;
    logic signed [35:0] r_pdy;
    logic signed [31:0] r_hx;
    logic signed [31:0] r_hy;
    logic signed [36:0] r_dot;
    logic signed [54:0] r_prx;
    logic signed [54:0] r_pry;
    logic signed [17:0] w_rx;
    logic signed [17:0] w_ry;

    always_ff @(posedge i_clk) begin
        if (c_ready && w_in_acc && w_func == FN_CAST) begin
            r_ax <= w_ax;
            r_ay <= w_ay;
            r_tp <= w_tp;
            r_te <= w_te;
        end
        if (r_state == ST_UDIR && w_uv_done) begin
            r_ux <= w_uv_ua;
            r_uy <= w_uv_ub;
        end
        if (r_state == ST_NDIR && w_uv_done) begin
            r_nx <= w_uv_ua;
            r_ny <= w_uv_ub;
        end
        if (r_state == ST_MUL) begin
            r_ptx <= 50'($signed({1'b0, r_best_t})) * 50'(r_ux);
            r_pty <= 50'($signed({1'b0, r_best_t})) * 50'(r_uy);
            r_pdx <= 36'(r_ux) * 36'(r_nx);
            r_pdy <= 36'(r_uy) * 36'(r_ny);
        end
        if (r_state == ST_SUM) begin
            r_hx  <= f_sat32(36'(r_ax) + 36'(f_rnd16(r_ptx)));
            r_hy  <= f_sat32(36'(r_ay) + 36'(f_rnd16(r_pty)));
            r_dot <= 37'(r_pdx) + 37'(r_pdy);
        end
        if (r_state == ST_MUL2) begin
            r_prx <= 55'(r_dot) * 55'(r_nx);
            r_pry <= 55'(r_dot) * 55'(r_ny);
        end
    end

    assign w_rx = f_clamp(26'(r_ux) - 26'(f_rnd31(r_prx)));
    assign w_ry = f_clamp(26'(r_uy) - 26'(f_rnd31(r_pry)));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (c_out_load) begin
            o_m_axis_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            o_m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            o_m_axis_tuser <= r_found;
            if (r_found) begin
                o_m_axis_tdata <= {3'd0, 1'b0, r_best_te, 1'b0, r_best_tp, w_ry, w_rx,
                                   r_hy, r_hx, r_best_t};
            end else begin
                o_m_axis_tdata <= {3'd0, TAG_NONE, TAG_NONE, r_uy, r_ux,
                                   32'd0, 32'd0, 31'd0};
            end
        end
    end

endmodule

// ===== hdl/rsnh_seg_cell.sv =====
`timescale 1ns / 1ps
module rsnh_seg_cell
    import rsnh_pkg::*;
(
    input  logic i_clk,
    input  logic i_shift,
    input  logic i_load,
    input  t_seg i_load_seg,
    input  t_seg i_next,
    output t_seg o_seg
);

    t_seg r_seg;

    // capture a new segment, or rotate one place toward the head
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seg <= i_load_seg;
        end else if (i_shift) begin
            r_seg <= i_next;
        end
    end

    assign o_seg = r_seg;

endmodule

// ===== hdl/rsnh_div_cell.sv =====
`timescale 1ns / 1ps
module rsnh_div_cell
    import rsnh_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_beat i_beat,
    output t_div_beat o_beat
);

    t_div_beat        r_beat;
    t_div_beat        n_beat;
    logic [REM_W-1:0] w_dsh;

    // one restoring step: quotient bit BIT; valid bit cleared in reset
    always_comb begin
        n_beat    = i_beat;
        n_beat.ok = i_beat.ok && i_rst_n;
        w_dsh     = REM_W'(i_beat.den) << BIT;
        if (!i_beat.sat && i_beat.rem >= w_dsh) begin
            n_beat.rem    = i_beat.rem - w_dsh;
            n_beat.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_beat = r_beat;

endmodule

// ===== hdl/rsnh_uvec.sv =====
`timescale 1ns / 1ps
module rsnh_uvec
    import rsnh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic               o_done,
    output logic signed [17:0] o_ua,
    output logic signed [17:0] o_ub
);

    t_uv_state   r_state;
    t_uv_state   n_state;
    logic [32:0] r_ma;
    logic [32:0] r_mb;
    logic        r_sa;
    logic        r_sb;
    logic [61:0] r_pa;
    logic [61:0] r_pb;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [49:0] r_na;
    logic [49:0] r_nb;
    logic [49:0] r_dsh;
    logic [17:0] r_qa;
    logic [17:0] r_qb;
    logic [4:0]  r_cnt;
    logic [32:0] w_m;
    logic [63:0] w_trial;
    logic [17:0] w_qa_c;
    logic [17:0] w_qb_c;

    assign w_m     = (r_ma > r_mb) ? r_ma : r_mb;
    assign w_trial = r_res + r_bit;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            UV_IDLE:  if (i_start) n_state = UV_SCALE;
            UV_SCALE: begin
                if (w_m == 33'd0) begin
                    n_state = UV_DONE;
                end else if (w_m[32:31] == 2'b00 && w_m[30]) begin
                    n_state = UV_SQ;
                end
            end
            UV_SQ:    n_state = UV_SUM;
            UV_SUM:   n_state = UV_SQRT;
            UV_SQRT:  if (r_bit[0]) n_state = UV_RND;
            UV_RND:   n_state = UV_DIV;
            UV_DIV:   if (r_cnt == 5'd0) n_state = UV_DONE;
            UV_DONE:  n_state = UV_IDLE;
            default:  n_state = UV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= UV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath: scale, square, root, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            UV_IDLE: begin
                r_sa <= i_a[32];
                r_sb <= i_b[32];
                r_ma <= i_a[32] ? 33'(-i_a) : 33'(i_a);
                r_mb <= i_b[32] ? 33'(-i_b) : 33'(i_b);
            end
            UV_SCALE: begin
                if (w_m == 33'd0) begin
                    r_qa <= 18'd0;
                    r_qb <= 18'd0;
                end else if (w_m[32:31] != 2'b00) begin
                    r_ma <= r_ma >> 1;
                    r_mb <= r_mb >> 1;
                end else if (!w_m[30]) begin
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb << 1;
                end
            end
            UV_SQ: begin
                r_pa <= 62'(r_ma[30:0]) * 62'(r_ma[30:0]);
                r_pb <= 62'(r_mb[30:0]) * 62'(r_mb[30:0]);
            end
            UV_SUM: begin
                r_x   <= 64'(r_pa) + 64'(r_pb);
                r_res <= 64'd0;
                r_bit <= 64'd1 << 62;
            end
            UV_SQRT: begin
                if (r_x >= w_trial) begin
                    r_x   <= r_x - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            UV_RND: begin
                r_na  <= (50'(r_ma[30:0]) << 16) + 50'(r_res[31:1]);
                r_nb  <= (50'(r_mb[30:0]) << 16) + 50'(r_res[31:1]);
                r_dsh <= 50'(r_res[31:0]) << 17;
                r_qa  <= 18'd0;
                r_qb  <= 18'd0;
                r_cnt <= 5'd17;
            end
            UV_DIV: begin
                if (r_na >= r_dsh) begin
                    r_na <= r_na - r_dsh;
                    r_qa <= {r_qa[16:0], 1'b1};
                end else begin
                    r_qa <= {r_qa[16:0], 1'b0};
                end
                if (r_nb >= r_dsh) begin
                    r_nb <= r_nb - r_dsh;
                    r_qb <= {r_qb[16:0], 1'b1};
                end else begin
                    r_qb <= {r_qb[16:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 5'd1;
            end
            UV_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // outputs: clamp to one and restore sign
    always_comb begin
        w_qa_c = (r_qa > 18'd65536) ? 18'd65536 : r_qa;
        w_qb_c = (r_qb > 18'd65536) ? 18'd65536 : r_qb;
        o_ua   = r_sa ? -$signed(w_qa_c) : $signed(w_qa_c);
        o_ub   = r_sb ? -$signed(w_qb_c) : $signed(w_qb_c);
        o_done = (r_state == UV_DONE);
    end

endmodule

// ===== verif/rsnh_checker.sv =====
`timescale 1ns / 1ps
module rsnh_checker
    import rsnh_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int MAX_POLYGONS = 16,
    parameter int MAX_EDGES    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [143:0] i_s_tdata,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [143:0] i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending,
    output int           o_casts,
    output int           o_hits
);

    typedef struct {
        logic        hit;
        logic [30:0] t;
        logic [31:0] hx;
        logic [31:0] hy;
        logic [17:0] rx;
        logic [17:0] ry;
        logic [4:0]  hp;
        logic [4:0]  he;
    } t_cast_result;

    // shadow copy of the segment store
    longint      seg_sx [MAX_SEGMENTS];
    longint      seg_sy [MAX_SEGMENTS];
    longint      seg_ex [MAX_SEGMENTS];
    longint      seg_ey [MAX_SEGMENTS];
    int          seg_tp [MAX_SEGMENTS];
    int          seg_te [MAX_SEGMENTS];
    int          seg_num;
    t_cast_result cast_results_q[$];

    assign o_pending = cast_results_q.size();

    task automatic report(input string what, input longint want, input longint got);
        $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
        o_errors++;
    endtask

    function automatic longint unsigned magn(input longint x);
        return x < 0 ? longint'(-x) : x;
    endfunction

    // magnitude rounding half away from zero
    function automatic longint round_shift(input longint x, input int n);
        longint unsigned m;
        m = (magn(x) + (64'd1 << (n - 1))) >> n;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clamp_unit(input longint x);
        if (x > 65536) return 65536;
        if (x < -65536) return -65536;
        return x;
    endfunction

    // Q16.16 unit vector of (a, b), scaled first so the larger part sits in [2^30, 2^31)
    function automatic void unit_dir(input longint a, input longint b,
                                     output longint oa, output longint ob);
        longint unsigned ma, mb, m, sq, res, bt, len, qa, qb;
        ma = magn(a);
        mb = magn(b);
        m  = ma > mb ? ma : mb;
        if (m == 0) begin
            oa = 0;
            ob = 0;
            return;
        end
        while (m >= 64'h8000_0000) begin
            ma >>= 1; mb >>= 1; m >>= 1;
        end
        while (m < 64'h4000_0000) begin
            ma <<= 1; mb <<= 1; m <<= 1;
        end
        sq  = ma * ma + mb * mb;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > sq) bt >>= 2;
        while (bt != 0) begin
            if (sq >= res + bt) begin
                sq  = sq - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        len = res;
        qa = (ma * 65536 + len / 2) / len;
        qb = (mb * 65536 + len / 2) / len;
        if (qa > 65536) qa = 65536;
        if (qb > 65536) qb = 65536;
        oa = a < 0 ? -longint'(qa) : longint'(qa);
        ob = b < 0 ? -longint'(qb) : longint'(qb);
    endfunction

    // nearest hit over the shadow store, then reflection
    function automatic t_cast_result trace_ray(input longint ax, input longint ay,
                                               input longint bx, input longint by,
                                               input int tp, input int te);
        t_cast_result r;
        longint ux, uy, vx, vy, dx, dy, den, sn, nx, ny, dot, rx, ry;
        logic signed [127:0] tn, wvx, wvy, wdx, wdy;
        logic [127:0] num, q;
        logic [30:0] tq, best_t;
        bit found;
        int best_i;
        found  = 0;
        best_t = 0;
        best_i = 0;
        unit_dir(bx, by, ux, uy);
        for (int i = 0; i < seg_num; i++) begin
            vx  = seg_ex[i] - seg_sx[i];
            vy  = seg_ey[i] - seg_sy[i];
            dx  = ax - seg_sx[i];
            dy  = ay - seg_sy[i];
            den = ux * vy - uy * vx;
            if (den == 0) continue;
            sn = ux * dy - uy * dx;
            if (den > 0 ? (sn < 0 || sn > den) : (sn > 0 || sn < den)) continue;
            if (seg_tp[i] == tp && seg_te[i] == te) continue;
            wvx = vx; wvy = vy; wdx = dx; wdy = dy;
            tn  = wvx * wdy - wvy * wdx;
            if (tn == 0) continue;
            if (tn[127] != (den < 0)) continue;
            num = tn[127] ? -tn : tn;
            num = num << 16;
            q   = num / magn(den);
            tq  = (q > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : q[30:0];
            if (!found || tq < best_t) begin
                found  = 1;
                best_t = tq;
                best_i = i;
            end
        end
        rx = ux;
        ry = uy;
        r.hit = found;
        r.t   = 0;
        r.hx  = 0;
        r.hy  = 0;
        r.hp  = TAG_NONE;
        r.he  = TAG_NONE;
        if (found) begin
            vx   = seg_ex[best_i] - seg_sx[best_i];
            vy   = seg_ey[best_i] - seg_sy[best_i];
            r.t  = best_t;
            r.hx = 32'(sat32(ax + round_shift(longint'(best_t) * ux, 16)));
            r.hy = 32'(sat32(ay + round_shift(longint'(best_t) * uy, 16)));
            unit_dir(vy, -vx, nx, ny);
            dot  = ux * nx + uy * ny;
            rx   = clamp_unit(ux - round_shift(dot * nx, 31));
            ry   = clamp_unit(uy - round_shift(dot * ny, 31));
            r.hp = 5'(seg_tp[best_i]);
            r.he = 5'(seg_te[best_i]);
        end
        r.rx = 18'(rx);
        r.ry = 18'(ry);
        return r;
    endfunction

    // input side: update the shadow store, queue cast predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seg_num = 0;
        end else if (i_s_tvalid && i_s_tready) begin
            longint ax, ay, bx, by;
            int tp, te;
            ax = $signed(i_s_tdata[31:0]);
            ay = $signed(i_s_tdata[63:32]);
            bx = $signed(i_s_tdata[95:64]);
            by = $signed(i_s_tdata[127:96]);
            tp = $signed(i_s_tdata[132:128]);
            te = $signed(i_s_tdata[137:133]);
            case (i_s_tuser)
                FN_CLEAR: seg_num = 0;
                FN_LOAD: begin
                    if (seg_num < MAX_SEGMENTS && tp >= 0 && tp < MAX_POLYGONS &&
                        te >= 0 && te < MAX_EDGES) begin
                        seg_sx[seg_num] = ax;
                        seg_sy[seg_num] = ay;
                        seg_ex[seg_num] = bx;
                        seg_ey[seg_num] = by;
                        seg_tp[seg_num] = tp;
                        seg_te[seg_num] = te;
                        seg_num++;
                    end
                end
                FN_CAST: cast_results_q.push_back(trace_ray(ax, ay, bx, by, tp, te));
                default: ;
            endcase
        end
    end

    // output side: compare each beat with the oldest prediction
    initial begin
        o_errors = 0;
        o_casts  = 0;
        o_hits   = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            t_cast_result w;
            if (cast_results_q.size() == 0) begin
                report("unexpected result beat", 0, 1);
            end else begin
                w = cast_results_q.pop_front();
                o_casts++;
                if (w.hit) o_hits++;
                if (i_m_tuser !== w.hit) report("valid_hit", w.hit, i_m_tuser);
                if (i_m_tdata[30:0] !== w.t) report("hit_t", w.t, i_m_tdata[30:0]);
                if (i_m_tdata[62:31] !== w.hx) report("hit_x", w.hx, i_m_tdata[62:31]);
                if (i_m_tdata[94:63] !== w.hy) report("hit_y", w.hy, i_m_tdata[94:63]);
                if (i_m_tdata[112:95] !== w.rx) report("refl_x", w.rx, i_m_tdata[112:95]);
                if (i_m_tdata[130:113] !== w.ry) report("refl_y", w.ry, i_m_tdata[130:113]);
                if (i_m_tdata[135:131] !== w.hp)
                    report("hit_poly", w.hp, i_m_tdata[135:131]);
                if (i_m_tdata[140:136] !== w.he)
                    report("hit_edge", w.he, i_m_tdata[140:136]);
            end
        end
    end

endmodule

// ===== verif/ray_segment_nearest_hit_reflect_tb.sv =====
`timescale 1ns / 1ps
module ray_segment_nearest_hit_reflect_tb;
    import rsnh_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [1:0]  fn;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] bx;
        logic [31:0] by;
        logic [4:0]  tp;
        logic [4:0]  te;
        bit          no_gap;
        bit          drain_first;
        bit          hold_sink;
    } t_beat;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tuser;
    int           errors, pending, casts, hits;
    int           idle_cycles;
    bit           hold_req;
    t_beat        beats_q[$];
    int           load_cnt, cast_cnt;

    ray_segment_nearest_hit_reflect dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    rsnh_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_casts    (casts),
        .o_hits     (hits)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic push(input logic [1:0] fn, input logic [31:0] ax, input logic [31:0] ay,
                        input logic [31:0] bx, input logic [31:0] by,
                        input logic [4:0] tp, input logic [4:0] te);
        t_beat b;
        b.fn = fn; b.ax = ax; b.ay = ay; b.bx = bx; b.by = by; b.tp = tp; b.te = te;
        b.no_gap = 0; b.drain_first = 0; b.hold_sink = 0;
        beats_q.push_back(b);
        if (fn == FN_LOAD) load_cnt++;
        if (fn == FN_CAST) cast_cnt++;
    endtask

    // coordinate within about +/-64.0, random fraction
    function automatic logic [31:0] near_coord();
        return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
    endfunction

    // small direction, or occasionally any 32-bit value
    function automatic logic [31:0] dir_comp();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 8)) - 32'd4;
            default: return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
        endcase
    endfunction

    task automatic build_directed();
        // empty store
        push(FN_CAST, 0, 0, 32'h0001_0000, 0, TAG_NONE, TAG_NONE);
        // vertical wall at x = 10, horizontal wall at y = 20
        push(FN_LOAD, 32'h000A_0000, 32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 0, 0);
        push(FN_LOAD, 32'hFFEC_0000, 32'h0014_0000, 32'h0014_0000, 32'h0014_0000, 15, 15);
        // bad tags are dropped
        push(FN_LOAD, 0, 0, 32'h0001_0000, 32'h0001_0000, 5'h1F, 5'd2);
        push(FN_LOAD, 0, 0, 32'h0001_0000, 32'h0001_0000, 5'd2, 5'h10);
        // extreme coordinates
        push(FN_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 3, 4);
        // duplicate of the vertical wall, ties go to the earlier one
        push(FN_LOAD, 32'h000A_0000, 32'hFFF6_0000, 32'h000A_0000, 32'h000A_0000, 7, 9);
        push(FN_CAST, 0, 0, 32'h0001_0000, 0, TAG_NONE, TAG_NONE);
        push(FN_CAST, 0, 0, 32'h0003_0000, 32'h0004_0000, TAG_NONE, TAG_NONE);
        // zero direction
        push(FN_CAST, 0, 0, 0, 0, TAG_NONE, TAG_NONE);
        // skip the first wall
        push(FN_CAST, 0, 0, 32'h0001_0000, 0, 0, 0);
        // parallel to the vertical wall
        push(FN_CAST, 32'h0005_0000, 0, 0, 32'h0001_0000, TAG_NONE, TAG_NONE);
        // aimed at a wall endpoint
        push(FN_CAST, 0, 0, 32'h000A_0000, 32'h000A_0000, TAG_NONE, TAG_NONE);
        // extreme direction and origin
        push(FN_CAST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             TAG_NONE, TAG_NONE);
        push(FN_CAST, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3, 4);
        push(FN_CAST, 32'h0000_0001, 0, 32'hFFFF_FFFF, 32'h0000_0001, TAG_NONE, TAG_NONE);
        // unused function code
        push(FN_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(), 5'd1, 5'd1);
        push(FN_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), 5'd0, 5'd0);
        push(FN_CAST, 0, 0, 32'h0001_0000, 0, TAG_NONE, TAG_NONE);
    endtask

    task automatic build_random();
        int phase;
        int nseg, ncast;
        int tps[$], tes[$];
        logic [4:0] tp, te;
        bit burst;
        int k;
        int j;
        phase = 0;
        while (beats_q.size() < 1650) begin
            burst = ($urandom_range(0, 5) == 0);
            k = beats_q.size();
            if ($urandom_range(0, 2) != 0 || phase % 16 == 9) begin
                push(FN_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                     5'($urandom()), 5'($urandom()));
                tps.delete();
                tes.delete();
            end
            // one phase in sixteen overfills the store
            nseg = (phase % 16 == 9) ? 70 : $urandom_range(1, 10);
            for (int i = 0; i < nseg; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    tp = 5'($urandom());
                    te = 5'($urandom());
                    push(FN_LOAD, $urandom(), $urandom(), $urandom(), $urandom(), tp, te);
                end else begin
                    tp = 5'($urandom_range(0, 15));
                    te = 5'($urandom_range(0, 15));
                    push(FN_LOAD, near_coord(), near_coord(), near_coord(), near_coord(),
                         tp, te);
                end
                tps.push_back(tp);
                tes.push_back(te);
            end
            ncast = $urandom_range(2, 8);
            for (int i = 0; i < ncast; i++) begin
                case ($urandom_range(0, 5))
                    0: begin
                        tp = 5'($urandom());
                        te = 5'($urandom());
                    end
                    1, 2: begin
                        j = $urandom_range(0, tps.size() - 1);
                        tp = tps[j];
                        te = tes[j];
                    end
                    default: begin
                        tp = TAG_NONE;
                        te = TAG_NONE;
                    end
                endcase
                if ($urandom_range(0, 11) == 0)
                    push(FN_CAST, $urandom(), $urandom(), $urandom(), $urandom(), tp, te);
                else
                    push(FN_CAST, near_coord(), near_coord(), dir_comp(), dir_comp(), tp, te);
            end
            if ($urandom_range(0, 15) == 0)
                push(FN_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(),
                     5'($urandom()), 5'($urandom()));
            if (burst)
                foreach (beats_q[i]) if (i >= k) beats_q[i].no_gap = 1;
            if (phase == 6) beats_q[beats_q.size() - 1].hold_sink = 1;
            if (phase % 25 == 12) beats_q[beats_q.size() - 1].drain_first = 1;
            phase++;
        end
    endtask

    // source side
    task automatic send_all();
        t_beat b;
        int gap;
        while (beats_q.size() != 0) begin
            b = beats_q.pop_front();
            if (b.drain_first) begin
                s_tvalid = 0;
                while (pending != 0) @(negedge i_clk);
            end
            if (b.hold_sink) hold_req = 1;
            gap = b.no_gap ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                s_tvalid = 0;
                repeat (gap) @(negedge i_clk);
            end
            s_tvalid = 1;
            s_tuser  = b.fn;
            s_tdata  = {6'd0, b.te, b.tp, b.by, b.bx, b.ay, b.ax};
            do @(posedge i_clk); while (!s_tready);
            @(negedge i_clk);
        end
        s_tvalid = 0;
    endtask

    // sink side: random stalls, a no-stall stretch every other 64 beats, one long hold
    initial begin
        int n, beats;
        m_tready = 0;
        beats = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                m_tready = 0;
                hold_req = 0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            n = ((beats / 64) % 2 == 1) ? 0 : $urandom_range(0, 7);
            if (n != 0) begin
                m_tready = 0;
                repeat (n) @(negedge i_clk);
            end
            m_tready = 1;
            do @(posedge i_clk); while (!m_tvalid);
            beats++;
            @(negedge i_clk);
        end
    end

    // no-progress watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 0;
        s_tvalid    = 0;
        s_tdata     = '0;
        s_tuser     = FN_CLEAR;
        hold_req    = 0;
        idle_cycles = 0;
        load_cnt    = 0;
        cast_cnt    = 0;
        build_directed();
        build_random();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        send_all();
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("loads sent %0d, casts sent %0d; results checked %0d, of them hits %0d",
                 load_cnt, cast_cnt, casts, hits);
        $display("covered clear, load, cast, dropped loads, full store and back-pressure");
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
